// ----- rtl/prefix_topology_distance_macros.svh -----
// Assertion macros used by the checker file.
`ifndef PREFIX_TOPOLOGY_DISTANCE_MACROS_SVH
`define PREFIX_TOPOLOGY_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled in reset.
`define PTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- rtl/ptd_pkg.sv -----
// Shared constants and types of the prefix topology distance block.
package ptd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int MAX_LEVELS  = 4;
    localparam int PATH_BITS   = 16;
    localparam int IN_LEVELS   = 4;

    localparam int ADDR_W   = 32;
    localparam int LABEL_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int NUM_W    = 5;
    localparam int LEV_W    = 3;
    localparam int DIST_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DEP_W  = $clog2(MAX_LEVELS + 1);
    localparam int ROW_W  = MAX_LEVELS * PATH_BITS;
    localparam int ENT_W  = 2 * ADDR_W;

    // Request commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_NUM_ENTRIES = 1'b0;
    localparam logic REG_LEVELS      = 1'b1;

    typedef logic [ROW_W-1:0]  t_path_row;
    typedef logic [ENT_W-1:0]  t_entry_row;

endpackage

// ----- rtl/ptd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/prefix_topology_distance.sv -----
// Top level: first-match IPv4 prefix table and topology distance sequencer.
//
// Input channel i_valid / o_stall carries one request per accept. A write
// request (cmd 0) stores one table slot and gives no result.
// A distance request (cmd 1) gives exactly one result on o_valid / i_stall.
// A distance request scans the table one entry per cycle through the entry
// RAM read port, comparing both query addresses against each entry, then
// reads the two matched paths and walks the labels one level per cycle.
// The block holds o_stall high for the whole distance request, so a new
// request is taken only once the sequencer is idle again; write requests
// are taken one per cycle while it is idle.
// A finished result waits in the output register while the next request is
// taken; if i_stall holds that register, a second result waits in the
// sequencer until the first one is taken.
// Reset (i_rst_n low, synchronous) clears the sequencer and output valid and
// sets num_entries and levels to 1; the table contents are not cleared.
// Registers are written over the APB port at byte addresses 0 and 4.
module prefix_topology_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [ptd_pkg::SLOT_W-1:0]    i_entry_index,
    input  logic [ptd_pkg::ADDR_W-1:0]    i_entry_addr,
    input  logic [ptd_pkg::ADDR_W-1:0]    i_entry_mask,
    input  logic [ptd_pkg::LABEL_W-1:0]   i_path_level0,
    input  logic [ptd_pkg::LABEL_W-1:0]   i_path_level1,
    input  logic [ptd_pkg::LABEL_W-1:0]   i_path_level2,
    input  logic [ptd_pkg::LABEL_W-1:0]   i_path_level3,
    input  logic [ptd_pkg::ADDR_W-1:0]    i_query_addr_a,
    input  logic [ptd_pkg::ADDR_W-1:0]    i_query_addr_b,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptd_pkg::DIST_W-1:0]    o_topo_distance,
    output logic                          o_found_a,
    output logic                          o_found_b,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptd_pkg::PADDR_W-1:0]   paddr,
    input  logic [ptd_pkg::PDATA_W-1:0]   pwdata,
    output logic [ptd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import ptd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PATHA = 3'd2;
    localparam logic [2:0] S_PATHB = 3'd3;
    localparam logic [2:0] S_PATHC = 3'd4;
    localparam logic [2:0] S_LVL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [NUM_W-1:0]    r_num_entries;
    logic [LEV_W-1:0]    r_levels;

    logic [ADDR_W-1:0]   r_qa, r_qb;
    logic                r_eq;
    logic [CNT_W-1:0]    r_n;
    logic [DEP_W-1:0]    r_depth;
    logic [CNT_W-1:0]    r_idx;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pidx;
    logic                r_ha, r_hb;
    logic [IDX_W-1:0]    r_sa, r_sb;
    t_path_row           r_pa, r_pb;
    logic [DEP_W-1:0]    r_lvl;

    logic                r_ovalid;
    logic [DIST_W-1:0]   r_odist;
    logic                r_ofa, r_ofb;

    logic                w_accept;
    logic                w_wr;
    logic [IDX_W-1:0]    w_wslot;
    t_entry_row          w_ent_wdata;
    t_entry_row          w_ent_rdata;
    t_path_row           w_path_wdata;
    t_path_row           w_path_rdata;
    logic [IDX_W-1:0]    w_path_raddr;
    logic [LABEL_W-1:0]  w_lbl [IN_LEVELS];
    logic [ADDR_W-1:0]   w_emask, w_eaddr;
    logic                w_match_a, w_match_b;
    logic                w_lvl_eq;
    logic [DEP_W:0]      w_dist_full;
    logic                w_out_free;
    logic                w_cfg_wr;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_wr     = w_accept && (i_cmd == CMD_WRITE) &&
                      (32'(i_entry_index) < MAX_ENTRIES);
    assign w_wslot  = IDX_W'(i_entry_index);

    assign w_lbl[0] = i_path_level0;
    assign w_lbl[1] = i_path_level1;
    assign w_lbl[2] = i_path_level2;
    assign w_lbl[3] = i_path_level3;

    always_comb begin
        w_path_wdata = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (l < IN_LEVELS) begin
                w_path_wdata[l*PATH_BITS +: PATH_BITS] = PATH_BITS'(w_lbl[l]);
            end
        end
    end

    assign w_ent_wdata  = {i_entry_addr, i_entry_mask};
    assign w_path_raddr = (r_state == S_PATHA) ? r_sa : r_sb;

    ptd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_wslot),
        .i_wdata (w_ent_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_ent_rdata)
    );

    ptd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_wslot),
        .i_wdata (w_path_wdata),
        .i_raddr (w_path_raddr),
        .o_rdata (w_path_rdata)
    );

    assign w_eaddr   = w_ent_rdata[ENT_W-1:ADDR_W];
    assign w_emask   = w_ent_rdata[ADDR_W-1:0];
    assign w_match_a = ((r_qa & w_emask) == (w_eaddr & w_emask));
    assign w_match_b = ((r_qb & w_emask) == (w_eaddr & w_emask));
    assign w_lvl_eq  = (r_lvl < r_depth) &&
                       (r_pa[PATH_BITS-1:0] == r_pb[PATH_BITS-1:0]);
    assign w_dist_full = {1'b0, r_depth} - {1'b0, r_lvl} + (DEP_W+1)'(1);
    assign w_out_free  = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept && i_cmd != CMD_WRITE) n_state = S_SCAN;
            S_SCAN:  if (r_idx >= r_n && !r_pend) n_state = S_PATHA;
            S_PATHA: n_state = S_PATHB;
            S_PATHB: n_state = S_PATHC;
            S_PATHC: n_state = S_LVL;
            S_LVL:   if (!w_lvl_eq) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pend <= (r_idx < r_n);
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qa    <= i_query_addr_a;
                r_qb    <= i_query_addr_b;
                r_eq    <= (i_query_addr_a == i_query_addr_b);
                r_n     <= (32'(r_num_entries) > MAX_ENTRIES) ?
                           CNT_W'(MAX_ENTRIES) : CNT_W'(r_num_entries);
                r_depth <= (32'(r_levels) > MAX_LEVELS) ?
                           DEP_W'(MAX_LEVELS) : DEP_W'(r_levels);
                r_idx   <= '0;
                r_ha    <= 1'b0;
                r_hb    <= 1'b0;
                r_sa    <= '0;
                r_sb    <= '0;
                r_lvl   <= '0;
            end
            S_SCAN: begin
                if (r_idx < r_n) begin
                    r_idx  <= r_idx + CNT_W'(1);
                    r_pidx <= r_idx[IDX_W-1:0];
                end
                if (r_pend) begin
                    if (!r_ha && w_match_a) begin
                        r_ha <= 1'b1;
                        r_sa <= r_pidx;
                    end
                    if (!r_hb && w_match_b) begin
                        r_hb <= 1'b1;
                        r_sb <= r_pidx;
                    end
                end
            end
            S_PATHB: r_pa <= r_ha ? w_path_rdata : '0;
            S_PATHC: r_pb <= r_hb ? w_path_rdata : '0;
            S_LVL: begin
                if (w_lvl_eq) begin
                    r_lvl <= r_lvl + DEP_W'(1);
                    r_pa  <= r_pa >> PATH_BITS;
                    r_pb  <= r_pb >> PATH_BITS;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_odist <= r_eq ? '0 : DIST_W'(w_dist_full);
                    r_ofa   <= r_ha;
                    r_ofb   <= r_hb;
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_topo_distance = r_odist;
    assign o_found_a       = r_ofa;
    assign o_found_b       = r_ofb;

    // APB registers; pready tied high, byte lanes below bit 2 ignored.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_entries <= NUM_W'(1);
            r_levels      <= LEV_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_NUM_ENTRIES: r_num_entries <= pwdata[NUM_W-1:0];
                REG_LEVELS:      r_levels      <= pwdata[LEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_ENTRIES: prdata = PDATA_W'(r_num_entries);
            REG_LEVELS:      prdata = PDATA_W'(r_levels);
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/ptd_checker.sv -----
// Port-level checker for the prefix topology distance block, with its bind.
`include "prefix_topology_distance_macros.svh"

module ptd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_cmd,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [ptd_pkg::DIST_W-1:0]  o_topo_distance,
    input logic                        o_found_a,
    input logic                        o_found_b
);

    import ptd_pkg::*;

    `PTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_topo_distance) && $stable(o_found_a) && $stable(o_found_b))
    `PTD_ASSERT_IMP(a_dist_range, i_clk, i_rst_n, o_valid, 32'(o_topo_distance) <= MAX_LEVELS + 1)
    `PTD_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_cmd == CMD_QUERY), o_stall)
    `PTD_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

endmodule

bind prefix_topology_distance ptd_checker u_ptd_checker (.*);

// ----- bench/tb_prefix_topology_distance.sv -----
// Testbench for prefix_topology_distance: directed and random requests, scoreboard check.
`timescale 1ns / 1ps

module tb_prefix_topology_distance;
    import ptd_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_NUM_ENTRIES = {REG_NUM_ENTRIES, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_LEVELS      = {REG_LEVELS, 2'b00};
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 72;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        bit                cmd;
        bit [SLOT_W-1:0]   idx;
        bit [ADDR_W-1:0]   ea;
        bit [ADDR_W-1:0]   em;
        bit [LABEL_W-1:0]  l0;
        bit [LABEL_W-1:0]  l1;
        bit [LABEL_W-1:0]  l2;
        bit [LABEL_W-1:0]  l3;
        bit [ADDR_W-1:0]   qa;
        bit [ADDR_W-1:0]   qb;
    } req_t;

    typedef struct packed {
        bit [DIST_W-1:0] topo;
        bit              fa;
        bit              fb;
    } dist_res_t;

    typedef struct packed {
        req_t      req;
        dist_res_t res;
    } dir_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_cmd = 1'b0;
    logic [SLOT_W-1:0]   i_entry_index = '0;
    logic [ADDR_W-1:0]   i_entry_addr = '0;
    logic [ADDR_W-1:0]   i_entry_mask = '0;
    logic [LABEL_W-1:0]  i_path_level0 = '0;
    logic [LABEL_W-1:0]  i_path_level1 = '0;
    logic [LABEL_W-1:0]  i_path_level2 = '0;
    logic [LABEL_W-1:0]  i_path_level3 = '0;
    logic [ADDR_W-1:0]   i_query_addr_a = '0;
    logic [ADDR_W-1:0]   i_query_addr_b = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DIST_W-1:0]   o_topo_distance;
    logic                o_found_a;
    logic                o_found_b;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    prefix_topology_distance u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_entry_addr    (i_entry_addr),
        .i_entry_mask    (i_entry_mask),
        .i_path_level0   (i_path_level0),
        .i_path_level1   (i_path_level1),
        .i_path_level2   (i_path_level2),
        .i_path_level3   (i_path_level3),
        .i_query_addr_a  (i_query_addr_a),
        .i_query_addr_b  (i_query_addr_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_topo_distance (o_topo_distance),
        .o_found_a       (o_found_a),
        .o_found_b       (o_found_b),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the table and registers
    bit [ADDR_W-1:0]  tab_addr [0:MAX_ENTRIES-1];
    bit [ADDR_W-1:0]  tab_mask [0:MAX_ENTRIES-1];
    bit [LABEL_W-1:0] tab_lab  [0:MAX_ENTRIES-1][0:MAX_LEVELS-1];
    bit [NUM_W-1:0]   cfg_num = NUM_W'(1);
    bit [LEV_W-1:0]   cfg_lev = LEV_W'(1);

    dist_res_t dist_q [$];
    dir_row_t  dir_rows [$];
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        hold_asks = 0;
    int        hold_seen = 0;
    int        stall_left = 0;
    bit        rx_quiet = 1'b0;
    bit        tx_quiet = 1'b0;

    int ph_num [0:NUM_PHASES-1] = '{16, 3, 0, 16, 31, 9, 20, 16};
    int ph_lev [0:NUM_PHASES-1] = '{4, 2, 1, 0, 7, 3, 5, 4};

    function automatic int match_slot(input bit [ADDR_W-1:0] a);
        int n;
        int slot;
        n = (cfg_num > MAX_ENTRIES) ? MAX_ENTRIES : cfg_num;
        slot = -1;
        for (int i = 0; i < n; i++) begin
            if (slot < 0 && ((a & tab_mask[i]) == (tab_addr[i] & tab_mask[i])))
                slot = i;
        end
        return slot;
    endfunction

    function automatic dist_res_t topo_lookup(input bit [ADDR_W-1:0] a,
                                              input bit [ADDR_W-1:0] b);
        int sa;
        int sb;
        int depth;
        int common;
        bit diverged;
        bit [LABEL_W-1:0] la;
        bit [LABEL_W-1:0] lb;
        dist_res_t res;
        sa = match_slot(a);
        sb = match_slot(b);
        depth = (cfg_lev > MAX_LEVELS) ? MAX_LEVELS : cfg_lev;
        common = 0;
        diverged = 1'b0;
        for (int l = 0; l < depth; l++) begin
            la = (sa >= 0) ? tab_lab[sa][l] : '0;
            lb = (sb >= 0) ? tab_lab[sb][l] : '0;
            if (!diverged && la == lb)
                common++;
            else
                diverged = 1'b1;
        end
        res.topo = (a == b) ? '0 : DIST_W'(depth - common + 1);
        res.fa = (sa >= 0);
        res.fb = (sb >= 0);
        return res;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.cmd = 1'($urandom);
        r.idx = SLOT_W'($urandom);
        r.ea  = $urandom;
        r.em  = $urandom;
        r.l0  = LABEL_W'($urandom);
        r.l1  = LABEL_W'($urandom);
        r.l2  = LABEL_W'($urandom);
        r.l3  = LABEL_W'($urandom);
        r.qa  = $urandom;
        r.qb  = $urandom;
        return r;
    endfunction

    function automatic bit [LABEL_W-1:0] pick_label();
        return ($urandom_range(0, 3) != 0) ? LABEL_W'($urandom_range(0, 3)) : LABEL_W'($urandom);
    endfunction

    function automatic req_t make_write();
        req_t r;
        r = rand_req();
        r.cmd = CMD_WRITE;
        case ($urandom_range(0, 9))
            0: r.em = $urandom;
            1: r.em = '1;
            default: r.em = 32'hFFFF_FFFF << (32 - $urandom_range(1, 31));
        endcase
        if ($urandom_range(0, 39) == 0)
            r.em = '0;
        r.l0 = pick_label();
        r.l1 = pick_label();
        r.l2 = pick_label();
        r.l3 = pick_label();
        return r;
    endfunction

    function automatic req_t make_query();
        req_t r;
        int j;
        int k;
        r = rand_req();
        r.cmd = CMD_QUERY;
        j = $urandom_range(0, MAX_ENTRIES - 1);
        k = $urandom_range(0, MAX_ENTRIES - 1);
        if ($urandom_range(0, 9) > 2)
            r.qa = (tab_addr[j] & tab_mask[j]) | (r.qa & ~tab_mask[j]);
        case ($urandom_range(0, 9))
            0, 1: r.qb = r.qa;
            2, 3, 4: r.qb = r.qa ^ (32'h1 << $urandom_range(0, 31));
            5, 6: ;
            default: r.qb = (tab_addr[k] & tab_mask[k]) | (r.qb & ~tab_mask[k]);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Called right after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input req_t r, input bit given, input dist_res_t res);
        dist_res_t want;
        i_cmd          <= r.cmd;
        i_entry_index  <= r.idx;
        i_entry_addr   <= r.ea;
        i_entry_mask   <= r.em;
        i_path_level0  <= r.l0;
        i_path_level1  <= r.l1;
        i_path_level2  <= r.l2;
        i_path_level3  <= r.l3;
        i_query_addr_a <= r.qa;
        i_query_addr_b <= r.qb;
        i_valid        <= 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        if (r.cmd == CMD_QUERY) begin
            want = given ? res : topo_lookup(r.qa, r.qb);
            dist_q = {dist_q, want};
        end else begin
            tab_addr[r.idx]   = r.ea;
            tab_mask[r.idx]   = r.em;
            tab_lab[r.idx][0] = r.l0;
            tab_lab[r.idx][1] = r.l1;
            tab_lab[r.idx][2] = r.l2;
            tab_lab[r.idx][3] = r.l3;
        end
    endtask

    task automatic sender_gap();
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (dist_q.size() != 0);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_NUM_ENTRIES: cfg_num = data[NUM_W-1:0];
            ADDR_LEVELS:      cfg_lev = data[LEV_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input int num, input int lev);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write(ADDR_NUM_ENTRIES, num);
        apb_write(ADDR_LEVELS, lev);
    endtask

    task automatic add_wr(input bit [SLOT_W-1:0] idx, input bit [ADDR_W-1:0] ea,
                          input bit [ADDR_W-1:0] em, input bit [LABEL_W-1:0] l0,
                          input bit [LABEL_W-1:0] l1, input bit [LABEL_W-1:0] l2,
                          input bit [LABEL_W-1:0] l3);
        dir_row_t row;
        row = '0;
        row.req.cmd = CMD_WRITE;
        row.req.idx = idx;
        row.req.ea  = ea;
        row.req.em  = em;
        row.req.l0  = l0;
        row.req.l1  = l1;
        row.req.l2  = l2;
        row.req.l3  = l3;
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_q(input bit [ADDR_W-1:0] qa, input bit [ADDR_W-1:0] qb,
                         input bit [DIST_W-1:0] topo, input bit fa, input bit fb);
        dir_row_t row;
        row = '0;
        row.req.cmd  = CMD_QUERY;
        row.req.qa   = qa;
        row.req.qb   = qb;
        row.res.topo = topo;
        row.res.fa   = fa;
        row.res.fb   = fb;
        dir_rows = {dir_rows, row};
    endtask

    // Result check
    always @(posedge i_clk) begin : result_check
        dist_res_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dist_q.size() == 0) begin
                report_mismatch("result with no query pending", int'(o_topo_distance), -1);
            end else begin
                want = dist_q.pop_front();
                if (o_topo_distance !== want.topo)
                    report_mismatch("topo_distance", int'(o_topo_distance), int'(want.topo));
                if (o_found_a !== want.fa)
                    report_mismatch("found_a", int'(o_found_a), int'(want.fa));
                if (o_found_b !== want.fb)
                    report_mismatch("found_b", int'(o_found_b), int'(want.fb));
            end
        end
    end

    // Result-side backpressure: random bursts, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            stall_left = LONG_HOLD;
        end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if (i_rst_n && stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        req_t r;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: one entry searched, one level
        add_wr(4'd0, 32'h0A00_0000, 32'hFF00_0000, 16'd1, 16'd2, 16'd3, 16'd4);
        add_q(32'h0A00_0001, 32'h0A00_0001, 3'd0, 1'b1, 1'b1);
        add_q(32'h0A00_0001, 32'h0B00_0000, 3'd2, 1'b1, 1'b0);
        add_q(32'h0A12_3456, 32'h0AFF_FFFF, 3'd1, 1'b1, 1'b1);
        add_q(32'hFFFF_FFFF, 32'h0000_0000, 3'd1, 1'b0, 1'b0);
        add_wr(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_wr(4'd0, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        add_q(32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1, 1'b1);
        add_q(32'h0000_0000, 32'h0000_0001, 3'd2, 1'b1, 1'b0);
        add_q(32'hFFFF_FFFF, 32'hFFFF_FFFE, 3'd1, 1'b0, 1'b0);
        add_wr(4'd0, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd7, 16'd8, 16'd9, 16'd10);
        add_q(32'hC0A8_01FF, 32'hC0A8_0100, 3'd1, 1'b1, 1'b1);
        add_q(32'hC0A8_0200, 32'hC0A8_0200, 3'd0, 1'b0, 1'b0);
        add_wr(4'd0, 32'h1234_5678, 32'h0000_0000, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_q(32'hDEAD_BEEF, 32'h0102_0304, 3'd1, 1'b1, 1'b1);
        add_wr(4'd0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'd1, 16'd2, 16'd3);
        add_q(32'h8000_0000, 32'h7FFF_FFFF, 3'd2, 1'b1, 1'b0);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, 1'b1, dir_rows[i].res);
            sender_gap();
        end

        // Fill every slot before wider searches
        for (int s = 0; s < MAX_ENTRIES; s++) begin
            r = make_write();
            r.idx = SLOT_W'(s);
            send_request(r, 1'b0, '0);
            sender_gap();
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_config(ph_num[ph], ph_lev[ph]);
            if (ph == NUM_PHASES - 1) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            for (int it = 0; it < PHASE_ITEMS; it++) begin
                if (ph == 2 && it == 5)
                    hold_asks <= hold_asks + 1;
                if (ph == 4 && it == PHASE_ITEMS / 2)
                    wait_results_drained();
                r = ($urandom_range(0, 9) < 3) ? make_write() : make_query();
                send_request(r, 1'b0, '0);
                sender_gap();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
